FILE: rtl/range_remap_table_defines.svh
// Assertion macros shared by the range remap table RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef RANGE_REMAP_TABLE_DEFINES_SVH
`define RANGE_REMAP_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rrt_pkg;

    // Operation codes carried in the func field.
    localparam logic [1:0] FUNC_LOAD      = 2'd0;
    localparam logic [1:0] FUNC_TRANSLATE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR     = 2'd2;

    // One beat as it travels down the chain of cells.
    typedef struct packed {
        logic        valid;
        logic [1:0]  func;
        logic [31:0] query;
        logic        found;
        logic [31:0] best_src;
        logic [31:0] best_dst;
        logic [31:0] best_len;
        logic        full;
    } token_t;

endpackage

`default_nettype wire

FILE: rtl/rrt_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rrt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] dest_start;
    logic [31:0] source_start;
    logic [31:0] span_length;
    logic [31:0] query_value;

    modport source (
        output valid, func, dest_start, source_start, span_length, query_value,
        input  ready
    );
    modport sink (
        input  valid, func, dest_start, source_start, span_length, query_value,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/rrt_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rrt_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] mapped_value;
    logic        matched;
    logic        status;

    modport source (
        output valid, mapped_value, matched, status,
        input  ready
    );
    modport sink (
        input  valid, mapped_value, matched, status,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/rrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module rrt_cell
    import rrt_pkg::*;
#(
    parameter int CNT_W = 7,
    parameter int INDEX = 0
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire logic             load_en,
    input  wire logic [CNT_W-1:0] load_ptr,
    input  wire logic [31:0]      load_dst,
    input  wire logic [31:0]      load_src,
    input  wire logic [31:0]      load_len,
    input  wire token_t           tok_in,
    input  wire logic [CNT_W-1:0] cnt_in,
    output token_t                tok_out,
    output logic [CNT_W-1:0]      cnt_out
);

    logic [31:0]      dst_reg;
    logic [31:0]      src_reg;
    logic [31:0]      len_reg;
    token_t           tok_reg;
    token_t           tok_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             take;

    // The stored range is written when a load beat targets this slot.
    always_ff @(posedge clk)
    begin
        if (load_en && (load_ptr == CNT_W'(INDEX)))
        begin
            dst_reg <= load_dst;
            src_reg <= load_src;
            len_reg <= load_len;
        end
    end

    // A translate beat adopts this range if it lies within the table as it stood
    // when the beat was accepted and has the largest source start so far.
    // Ties go to the later slot, which is the more recently loaded range.
    always_comb
    begin
        take = tok_in.valid && (tok_in.func == FUNC_TRANSLATE)
            && (cnt_in > CNT_W'(INDEX)) && (src_reg <= tok_in.query)
            && (!tok_in.found || (src_reg >= tok_in.best_src));
        tok_next = tok_in;
        if (take)
        begin
            tok_next.found    = 1'b1;
            tok_next.best_src = src_reg;
            tok_next.best_dst = dst_reg;
            tok_next.best_len = len_reg;
        end
    end

    // Hand the beat on to the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
            cnt_reg <= '0;
        end
        else if (advance)
        begin
            tok_reg <= tok_next;
            cnt_reg <= cnt_in;
        end
    end

    assign tok_out = tok_reg;
    assign cnt_out = cnt_reg;

endmodule

`default_nettype wire

FILE: rtl/rrt_resolve.sv
`timescale 1ns / 1ps
`default_nettype none

module rrt_resolve
    import rrt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic advance,
    input  wire token_t tok_in,
    rrt_out_if.source rsp
);

    logic        valid_reg;
    logic [31:0] mapped_reg;
    logic [31:0] mapped_next;
    logic        matched_reg;
    logic        matched_next;
    logic        status_reg;
    logic        status_next;
    logic [31:0] offset;

    // Only the selected range is tested; the sum wraps modulo 2^32.
    always_comb
    begin
        offset       = tok_in.query - tok_in.best_src;
        mapped_next  = '0;
        matched_next = 1'b0;
        status_next  = 1'b0;
        case (tok_in.func)
            FUNC_LOAD:
            begin
                status_next = tok_in.full;
            end
            FUNC_TRANSLATE:
            begin
                mapped_next = tok_in.query;
                if (tok_in.found && (offset < tok_in.best_len))
                begin
                    mapped_next  = tok_in.best_dst + offset;
                    matched_next = 1'b1;
                end
            end
            default:
            begin
                mapped_next = '0;
            end
        endcase
    end

    // Output register; it holds its beat until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mapped_reg  <= mapped_next;
            matched_reg <= matched_next;
            status_reg  <= status_next;
        end
    end

    assign rsp.valid        = valid_reg;
    assign rsp.mapped_value = mapped_reg;
    assign rsp.matched      = matched_reg;
    assign rsp.status       = status_reg;

endmodule

`default_nettype wire

FILE: rtl/range_remap_table.sv
// Range remap table. Each range is loaded with a load beat (func 0) and takes the next free
// slot; once ENTRIES slots are in use, further loads are dropped and answered with status 1.
// A clear beat (func 2) empties the table. A translate beat (func 1) selects the stored range
// with the largest source start that is not above the query; ties go to the range loaded
// last. If the query lies within that range, the result is the destination start plus the
// offset, modulo 2^32, and matched is set. Otherwise the query is returned unchanged. Every
// beat, code 3 included, gives exactly one result, in order. The table is a row of ENTRIES
// cells, each holding one range. A beat moves one cell per cycle in which the row advances
// and carries the entry count from the moment it was accepted, so later loads and clears do
// not affect it. A beat passes the cell row, then the output register. A new beat
// is accepted every cycle in which the output register is empty or being read.
`timescale 1ns / 1ps
`default_nettype none
`include "range_remap_table_defines.svh"

module range_remap_table
    import rrt_pkg::*;
#(
    parameter int ENTRIES = 64
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    rrt_in_if.sink    req,
    rrt_out_if.source rsp
);

    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             advance;
    logic             fire;
    logic             table_full;
    logic             load_en;
    token_t           head_tok;
    token_t           tok_chain [0:ENTRIES];
    logic [CNT_W-1:0] cnt_chain [0:ENTRIES];

    // The whole row moves whenever the output register can take a beat.
    assign advance    = !rsp.valid || rsp.ready;
    assign req.ready  = advance;
    assign fire       = req.valid && advance;
    assign table_full = (count_reg == CNT_W'(ENTRIES));
    assign load_en    = fire && (req.func == FUNC_LOAD) && !table_full;

    // Entry count update.
    always_comb
    begin
        count_next = count_reg;
        if (load_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (fire && (req.func == FUNC_CLEAR))
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Beat entering the first cell.
    always_comb
    begin
        head_tok          = '0;
        head_tok.valid    = fire;
        head_tok.func     = req.func;
        head_tok.query    = req.query_value;
        head_tok.full     = (req.func == FUNC_LOAD) && table_full;
    end

    assign tok_chain[0] = head_tok;
    assign cnt_chain[0] = count_reg;

    // Row of cells, one stored range in each.
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        rrt_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .load_en  (load_en),
            .load_ptr (count_reg),
            .load_dst (req.dest_start),
            .load_src (req.source_start),
            .load_len (req.span_length),
            .tok_in   (tok_chain[i]),
            .cnt_in   (cnt_chain[i]),
            .tok_out  (tok_chain[i+1]),
            .cnt_out  (cnt_chain[i+1])
        );
    end

    // Final offset check and output register.
    rrt_resolve u_resolve (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .tok_in  (tok_chain[ENTRIES]),
        .rsp     (rsp)
    );

    // The entry count never exceeds the table size.
    `RRT_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(ENTRIES), "entry count overflow")
    // A load into a table with room adds exactly one entry.
    `RRT_ASSERT_NEXT(a_load_grows, load_en, count_reg == $past(count_reg) + CNT_W'(1),
        "load did not add an entry")
    // An accepted clear empties the table.
    `RRT_ASSERT_NEXT(a_clear_empties, fire && (req.func == FUNC_CLEAR), count_reg == '0,
        "clear did not empty the table")
    // The row must not move while a result waits for the sink.
    `RRT_ASSERT_SAME(a_stall_blocks, rsp.valid && !rsp.ready, !req.ready,
        "input taken while the output is stalled")

endmodule

`default_nettype wire

FILE: test/range_remap_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the range remap table. Every request beat is run
// through a private copy of the range table to work out the response it must
// cause, and every response beat is compared with the oldest one still owed.
module range_remap_checker
    import rrt_pkg::*;
#(
    parameter int ENTRIES = 64
)
(
    input  logic clk,
    input  logic rst_n,
    rrt_in_if    req,
    rrt_out_if   rsp,
    output int   mismatch_count,
    output int   pending_count,
    output int   loads_seen,
    output int   translates_seen,
    output int   clears_seen,
    output int   hits_seen,
    output int   drops_seen
);

    typedef struct packed {
        logic [31:0] mapped_value;
        logic        matched;
        logic        status;
    } remap_result_t;

    // Private copy of the range table.
    logic [31:0] dest_tab   [ENTRIES];
    logic [31:0] source_tab [ENTRIES];
    logic [31:0] length_tab [ENTRIES];
    int          stored_ranges = 0;

    remap_result_t expected_responses[$];

    initial
    begin
        mismatch_count  = 0;
        pending_count   = 0;
        loads_seen      = 0;
        translates_seen = 0;
        clears_seen     = 0;
        hits_seen       = 0;
        drops_seen      = 0;
    end

    // Applies one request beat to the table copy and returns its response.
    function automatic remap_result_t table_response(input logic [1:0]  code,
                                                     input logic [31:0] dst,
                                                     input logic [31:0] src,
                                                     input logic [31:0] len,
                                                     input logic [31:0] q);
        remap_result_t r;
        logic          found;
        int            best;
        logic [31:0]   offset;
        r     = '0;
        found = 1'b0;
        best  = 0;
        case (code)
            FUNC_LOAD:
            begin
                if (stored_ranges < ENTRIES)
                begin
                    dest_tab[stored_ranges]   = dst;
                    source_tab[stored_ranges] = src;
                    length_tab[stored_ranges] = len;
                    stored_ranges++;
                end
                else
                begin
                    r.status = 1'b1;
                end
            end
            FUNC_TRANSLATE:
            begin
                r.mapped_value = q;
                // Largest source start not above the query; a later range wins a tie.
                for (int i = 0; i < stored_ranges; i++)
                begin
                    if (source_tab[i] <= q && (!found || source_tab[i] >= source_tab[best]))
                    begin
                        best  = i;
                        found = 1'b1;
                    end
                end
                // Only the selected range is tried.
                if (found)
                begin
                    offset = q - source_tab[best];
                    if (offset < length_tab[best])
                    begin
                        r.mapped_value = dest_tab[best] + offset;
                        r.matched      = 1'b1;
                    end
                end
            end
            FUNC_CLEAR:
            begin
                stored_ranges = 0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Predict on each request beat and check each response beat.
    always @(posedge clk)
    begin
        remap_result_t predicted;
        remap_result_t want;
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                predicted = table_response(req.func, req.dest_start, req.source_start,
                                           req.span_length, req.query_value);
                expected_responses.insert(expected_responses.size(), predicted);
                if (req.func == FUNC_LOAD)
                    loads_seen++;
                else if (req.func == FUNC_TRANSLATE)
                    translates_seen++;
                else if (req.func == FUNC_CLEAR)
                    clears_seen++;
                if (predicted.matched)
                    hits_seen++;
                if (predicted.status)
                    drops_seen++;
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_responses.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected response: mapped_value %h matched %b status %b",
                             $time, rsp.mapped_value, rsp.matched, rsp.status);
                end
                else
                begin
                    want = expected_responses.pop_front();
                    if (rsp.mapped_value !== want.mapped_value || rsp.matched !== want.matched
                        || rsp.status !== want.status)
                    begin
                        mismatch_count++;
                        $display("%0t: mismatch: expected mapped_value %h matched %b status %b",
                                 $time, want.mapped_value, want.matched, want.status);
                        $display("%0t:           actual mapped_value %h matched %b status %b",
                                 $time, rsp.mapped_value, rsp.matched, rsp.status);
                    end
                end
            end
            pending_count = expected_responses.size();
        end
    end

endmodule

FILE: test/tb_range_remap_table.sv
`timescale 1ns / 1ps

module tb_range_remap_table;
    import rrt_pkg::*;

    localparam int         ENTRIES      = 64;
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;
    localparam int         RANDOM_BEATS = 400;
    localparam int         LONG_HOLD    = 200;
    localparam int         STALL_LIMIT  = 1500;

    logic clk;
    logic rst_n;

    rrt_in_if  req ();
    rrt_out_if rsp ();

    int mismatch_count;
    int pending_count;
    int loads_seen;
    int translates_seen;
    int clears_seen;
    int hits_seen;
    int drops_seen;

    // Idling percentages and long hold requests, shared with the receiver.
    int tx_idle_pct = 8;
    int rx_idle_pct = 55;
    int holds_asked = 0;
    int holds_done  = 0;

    // Beats that do something; the unused code is not counted.
    int item_count  = 0;

    // Ranges the table should hold, kept only to steer queries towards them.
    logic [31:0] shadow_src[$];
    logic [31:0] shadow_len[$];

    range_remap_table #(.ENTRIES(ENTRIES)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    range_remap_checker #(.ENTRIES(ENTRIES)) u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req),
        .rsp             (rsp),
        .mismatch_count  (mismatch_count),
        .pending_count   (pending_count),
        .loads_seen      (loads_seen),
        .translates_seen (translates_seen),
        .clears_seen     (clears_seen),
        .hits_seen       (hits_seen),
        .drops_seen      (drops_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, or a long hold when one is requested.
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && holds_done != holds_asked)
            begin
                rsp.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
                holds_done++;
            end
            else
            begin
                rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a beat.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                    quiet_cycles = 0;
                else
                    quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
                    $display("*** FAILED ***");
                    $finish;
                end
            end
        end
    end

    function automatic logic [31:0] random_word();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Source starts: a small pool gives ties and overlaps, the top end gives wraps.
    function automatic logic [31:0] pick_source();
        case ($urandom_range(3))
            0:       return {16'h0, 4'($urandom_range(15)), 12'h000};
            1:       return 32'hFFFF_F000 + $urandom_range(4095);
            default: return random_word();
        endcase
    endfunction

    function automatic logic [31:0] pick_length();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom();
            default: return $urandom_range(4096, 1);
        endcase
    endfunction

    function automatic logic [31:0] pick_dest();
        if ($urandom_range(3) == 0)
            return 32'hFFFF_FFFF - $urandom_range(255);
        return random_word();
    endfunction

    // Queries aimed at the edges of a stored range, or anywhere.
    function automatic logic [31:0] pick_query();
        int          idx;
        logic [31:0] base;
        logic [31:0] span;
        if (shadow_src.size() == 0 || $urandom_range(4) == 0)
            return random_word();
        idx  = $urandom_range(shadow_src.size() - 1);
        base = shadow_src[idx];
        span = shadow_len[idx];
        case ($urandom_range(5))
            0:       return base;
            1:       return base + span - 32'd1;
            2:       return base + span;
            3:       return base - 32'd1;
            default: return base + ((span == 0) ? 32'd0 : 32'($urandom_range(span - 1)));
        endcase
    endfunction

    // Offers one request beat, after any idle cycles, and waits until it is taken.
    task automatic send_beat(input logic [1:0]  code,
                             input logic [31:0] dst,
                             input logic [31:0] src,
                             input logic [31:0] len,
                             input logic [31:0] q);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.func         <= code;
        req.dest_start   <= dst;
        req.source_start <= src;
        req.span_length  <= len;
        req.query_value  <= q;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        if (code != FUNC_UNUSED)
            item_count++;
    endtask

    task automatic load_range(input logic [31:0] dst, input logic [31:0] src,
                              input logic [31:0] len);
        send_beat(FUNC_LOAD, dst, src, len, $urandom());
        if (shadow_src.size() < ENTRIES)
        begin
            shadow_src.insert(shadow_src.size(), src);
            shadow_len.insert(shadow_len.size(), len);
        end
    endtask

    task automatic translate(input logic [31:0] q);
        send_beat(FUNC_TRANSLATE, $urandom(), $urandom(), $urandom(), q);
    endtask

    task automatic clear_table();
        send_beat(FUNC_CLEAR, $urandom(), $urandom(), $urandom(), $urandom());
        shadow_src.delete();
        shadow_len.delete();
    endtask

    // Stimulus and verdict.
    initial
    begin
        int random_goal;
        int third;
        int phase;
        int pick;
        int fills;

        req.valid        = 1'b0;
        req.func         = FUNC_LOAD;
        req.dest_start   = '0;
        req.source_start = '0;
        req.span_length  = '0;
        req.query_value  = '0;
        rst_n            = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats: empty table, range edges, ties, zero length and wrapping.
        translate(32'h0000_0000);
        translate(32'hFFFF_FFFF);
        load_range(32'h0000_1000, 32'h0000_0100, 32'h0000_0010);
        translate(32'h0000_0100);
        translate(32'h0000_010F);
        translate(32'h0000_0110);
        translate(32'h0000_00FF);
        // Same source start again: the newer, shorter range is the one tried.
        load_range(32'hAAAA_0000, 32'h0000_0100, 32'h0000_0004);
        translate(32'h0000_0105);
        translate(32'h0000_0102);
        load_range(32'h0000_0000, 32'h0000_0200, 32'h0000_0000);
        translate(32'h0000_0200);
        load_range(32'hFFFF_FFF0, 32'hFFFF_FF00, 32'hFFFF_FFFF);
        translate(32'hFFFF_FFFF);
        load_range(32'h1234_5678, 32'hFFFF_FFFF, 32'h0000_0001);
        translate(32'hFFFF_FFFF);
        load_range(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        translate(32'h0000_0050);
        send_beat(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        translate(32'h0000_0150);
        clear_table();
        translate(32'h0000_0102);
        load_range(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        translate(32'h0000_0000);
        clear_table();

        // Random part in three idling phases; a long output hold opens the first
        // and the last, so the block fills up and stops taking beats.
        random_goal = item_count + RANDOM_BEATS;
        third       = RANDOM_BEATS / 3;
        phase       = 1;
        fills       = 0;
        holds_asked++;
        while (item_count < random_goal)
        begin
            if (phase == 1 && item_count >= random_goal - 2 * third)
            begin
                phase       = 2;
                tx_idle_pct = 55;
                rx_idle_pct = 8;
            end
            else if (phase == 2 && item_count >= random_goal - third)
            begin
                phase       = 3;
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                holds_asked++;
            end
            pick = $urandom_range(99);
            if ((fills == 0 && item_count >= random_goal - 2 * third) || (fills < 2 && pick < 3))
            begin
                // Fill the table and push a few ranges past the end.
                clear_table();
                repeat (ENTRIES + $urandom_range(4, 1))
                    load_range(pick_dest(), pick_source(), pick_length());
                repeat (12)
                    translate(pick_query());
                fills++;
            end
            else if (pick < 12)
            begin
                clear_table();
            end
            else if (pick < 17)
            begin
                send_beat(FUNC_UNUSED, $urandom(), $urandom(), $urandom(), $urandom());
            end
            else
            begin
                repeat ($urandom_range(5, 1))
                    load_range(pick_dest(), pick_source(), pick_length());
                repeat ($urandom_range(10, 2))
                    translate(pick_query());
            end
        end
        req.valid <= 1'b0;

        // Drain, then allow the pipeline length for any stray response.
        while (pending_count != 0)
            @(posedge clk);
        repeat (ENTRIES + 8) @(posedge clk);

        $display("Covered %0d loads, %0d translates, %0d clears and %0d full-table fills.",
                 loads_seen, translates_seen, clears_seen, fills);
        $display("%0d translates hit a range and %0d loads were dropped; %0d mismatches.",
                 hits_seen, drops_seen, mismatch_count);
        if (mismatch_count == 0 && pending_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
